FILE: sv/ray_cone_intersection_assert.svh
// assertion macros for the ray cone intersection block
`ifndef RAY_CONE_INTERSECTION_ASSERT_SVH
`define RAY_CONE_INTERSECTION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RCI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// property that must hold while reset is applied
`define RCI_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge clk) !rst_n |-> (cons)) else $error(msg);

`endif

FILE: sv/rci_pkg.sv
// types, widths and constants shared by the ray cone intersection block
package rci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int LEN_W     = 31;
    localparam int Q_W       = 32;

    localparam int SQ_IN_W   = LEN_W + FRAC_BITS;
    localparam int SQ_ROOT_W = (SQ_IN_W + 1) / 2;
    localparam int DIV_LAT   = Q_W + 3;

    // stage numbers counted from the input register
    localparam int ST_SQRT   = SQ_ROOT_W;
    localparam int ST_SNUM   = ST_SQRT + 1;
    localparam int ST_SDIV   = ST_SNUM + DIV_LAT;
    localparam int ST_OUT    = ST_SDIV + 5;
    localparam int ST_BNUM   = 3;
    localparam int ST_BDIV   = ST_BNUM + DIV_LAT;
    localparam int ST_BRES   = ST_BDIV + 4;
    localparam int PIPE_DEPTH = ST_OUT + 1;

    localparam logic [63:0] EPS = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;
    localparam logic signed [Q_W-1:0] ONE_Q  = Q_W'(1) << FRAC_BITS;
    localparam logic signed [Q_W-1:0] MISS_T = -ONE_Q;

    localparam int IN_TDATA_W  = 248;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_APEX_X,
        REG_APEX_Y,
        REG_APEX_Z,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_HEIGHT,
        REG_RADIUS
    } cfg_reg_t;

    // one ray, last field in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0]          discriminant;
        logic signed [COORD_W-1:0] coef_b;
        logic signed [COORD_W-1:0] coef_a;
        logic signed [DIR_W-1:0]   direction_z;
        logic signed [DIR_W-1:0]   direction_y;
        logic signed [DIR_W-1:0]   direction_x;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_x;
    } ray_t;

    localparam int RAY_W = $bits(ray_t);

    // origin and direction carried alongside the arithmetic
    typedef struct packed {
        logic [2:0][DIR_W-1:0]   dir;
        logic [2:0][COORD_W-1:0] org;
    } geom_t;

    localparam int GEOM_W = $bits(geom_t);

    // one result, last field in the lowest bits
    typedef struct packed {
        logic                  base_hit;
        logic signed [Q_W-1:0] base_t;
        logic                  side_hit;
        logic signed [Q_W-1:0] side_t;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

FILE: sv/rci_delay.sv
// fixed-length register delay line with a shared enable
module rci_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    // shift one place per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

FILE: sv/rci_isqrt.sv
// pipelined integer square root, one root bit per stage
module rci_isqrt import rci_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [SQ_IN_W-1:0]   x,
    output logic [SQ_ROOT_W-1:0] root
);

    localparam int RM_W = SQ_IN_W + 2;

    logic [RM_W-1:0]      rem_reg [SQ_ROOT_W];
    logic [SQ_ROOT_W-1:0] r_reg   [SQ_ROOT_W];

    for (genvar k = 0; k < SQ_ROOT_W; k++)
    begin : g_stage
        localparam int J = SQ_ROOT_W - 1 - k;
        logic [RM_W-1:0]      src_rem;
        logic [SQ_ROOT_W-1:0] src_r;
        logic [RM_W-1:0]      trial;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign src_rem = RM_W'(x);
            assign src_r   = '0;
        end
        else
        begin : g_rest
            assign src_rem = rem_reg[k-1];
            assign src_r   = r_reg[k-1];
        end

        // (r + 2^j)^2 - r^2 against the remaining x - r^2
        assign trial = (RM_W'(src_r) << (J + 1)) + (RM_W'(1) << (2 * J));
        assign ge    = (src_rem >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (src_rem - trial) : src_rem;
                r_reg[k]   <= src_r | (SQ_ROOT_W'(ge) << J);
            end
        end
    end

    assign root = r_reg[SQ_ROOT_W-1];

endmodule

FILE: sv/rci_qdiv.sv
// pipelined fixed-point divide num*2^frac/den, truncated and saturated
module rci_qdiv import rci_pkg::*; #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [Q_W-1:0]   q
);

    localparam int REM_W = NUM_W + FRAC_BITS;
    localparam int CMP_W = (REM_W > DEN_W + Q_W) ? REM_W : DEN_W + Q_W;

    logic [NUM_W-1:0] un_reg;
    logic [DEN_W-1:0] ud_reg;
    logic             neg_a_reg;

    logic [REM_W-1:0] rem_reg [Q_W+1];
    logic [Q_W-1:0]   quo_reg [Q_W+1];
    logic [DEN_W-1:0] dv_reg  [Q_W+1];
    logic             neg_reg [Q_W+1];
    logic             sat_reg [Q_W+1];

    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] qc;
    logic [Q_W-1:0] q_reg;

    // magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            ud_reg    <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_a_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    // quotient of 2^32 or more saturates at once
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {un_reg, {FRAC_BITS{1'b0}}};
            quo_reg[0] <= '0;
            dv_reg[0]  <= ud_reg;
            neg_reg[0] <= neg_a_reg;
            sat_reg[0] <= (CMP_W'(un_reg) << FRAC_BITS) >= (CMP_W'(ud_reg) << Q_W);
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++)
    begin : g_bit
        localparam int B = Q_W - 1 - k;
        logic [CMP_W-1:0] trial;
        logic             ge;

        assign trial = CMP_W'(dv_reg[k]) << B;
        assign ge    = (CMP_W'(rem_reg[k]) >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? REM_W'(CMP_W'(rem_reg[k]) - trial) : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (Q_W'(ge) << B);
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    // clamp to the signed range and apply the sign
    assign lim = neg_reg[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    assign qc  = (sat_reg[Q_W] || (quo_reg[Q_W] > lim)) ? lim : quo_reg[Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= neg_reg[Q_W] ? (-qc) : qc;
        end
    end

    assign q = $signed(q_reg);

endmodule

FILE: sv/ray_cone_intersection.sv
// ray versus finite cone: side surface and base disk tests, fully pipelined
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  ray: origin, direction, a, b, disc
//  m_axis    out        m_axis_tvalid/m_axis_tready  side_t, side_hit, base_t, base_hit
//  cfg       in         cfg_valid/cfg_ready          register index and write data
//
//  one ray per cycle while the output is not stalled; each result passes through the square root
//  (one bit a stage) followed by the side divider (one bit a stage)
//  a stalled output freezes the whole pipeline and holds s_axis_tready low; nothing is lost
//  reset clears the valid bits and loads the register defaults; no clearing pass
//  cfg_ready is always high; derived cone values are registered from the configuration registers
module ray_cone_intersection import rci_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    // coef_a, coef_b, discriminant, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // side_t, side_hit, base_t, base_hit, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration and derived cone values
    logic signed [COORD_W-1:0] apex_reg [3];
    logic signed [DIR_W-1:0]   axis_reg [3];
    logic [LEN_W-1:0]          height_reg;
    logic [LEN_W-1:0]          radius_reg;
    logic signed [33:0]        cen_reg [3];
    logic [LEN_W+FRAC_BITS-1:0] hq_reg;
    logic [2*LEN_W-1:0]        rsq_reg;
    logic signed [49:0]        ah_prod [3];

    // pipeline control
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    ray_t                  ray_reg;
    geom_t                 geom_in;

    // side path
    logic [SQ_ROOT_W-1:0]      sq_root;
    logic [2*COORD_W-1:0]      ab_d;
    logic signed [33:0]        sn0_reg;
    logic signed [33:0]        sn1_reg;
    logic signed [32:0]        sd_reg;
    logic                      anz_reg;
    logic                      anz_d;
    logic signed [Q_W-1:0]     st_div [2];
    geom_t                     side_g;
    logic signed [49:0]        sdt_prod [2][3];
    logic signed [33:0]        sdt_reg [2][3];
    logic signed [32:0]        soa_reg [3];
    logic signed [34:0]        sh_reg [2][3];
    logic signed [52:0]        sp_reg [2][3];
    logic signed [54:0]        sproj_reg [2];
    logic signed [Q_W-1:0]     st_reg [4][2];
    logic                      stok_reg [4][2];
    logic                      sv_ok [2];
    logic signed [Q_W-1:0]     side_t_reg;
    logic                      side_hit_reg;

    // base path
    logic signed [34:0]        bco_reg [3];
    logic signed [35:0]        bda_reg [3];
    logic signed [35:0]        bda2_reg [3];
    logic signed [52:0]        bnp_reg [3];
    logic signed [54:0]        bnum_reg;
    logic signed [37:0]        bden_reg;
    logic [37:0]               bden_abs;
    logic                      den_ok;
    logic                      bok_d;
    logic signed [Q_W-1:0]     bt_div;
    geom_t                     base_g;
    logic signed [49:0]        bdt_prod [3];
    logic signed [33:0]        bdt_reg [3];
    logic signed [34:0]        boc_reg [3];
    logic signed [35:0]        bh_reg [3];
    logic [35:0]               babs [3];
    logic [LEN_W-1:0]          buh_reg [3];
    logic                      bout_reg [3];
    logic [2*LEN_W-1:0]        bsq_reg [3];
    logic signed [Q_W-1:0]     bt_reg [4];
    logic                      bok_reg [3];
    logic                      bin_reg;
    logic [63:0]               bsum;
    logic                      bhit;
    logic [Q_W:0]              bres;
    logic [Q_W:0]              bres_d;
    result_t                   res;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                apex_reg[i] <= '0;
                axis_reg[i] <= '0;
            end
            axis_reg[1] <= DIR_W'(ONE_Q);
            height_reg  <= LEN_W'(ONE_Q);
            radius_reg  <= LEN_W'(ONE_Q);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_APEX_X: apex_reg[0] <= $signed(cfg_data[COORD_W-1:0]);
                REG_APEX_Y: apex_reg[1] <= $signed(cfg_data[COORD_W-1:0]);
                REG_APEX_Z: apex_reg[2] <= $signed(cfg_data[COORD_W-1:0]);
                REG_AXIS_X: axis_reg[0] <= $signed(cfg_data[DIR_W-1:0]);
                REG_AXIS_Y: axis_reg[1] <= $signed(cfg_data[DIR_W-1:0]);
                REG_AXIS_Z: axis_reg[2] <= $signed(cfg_data[DIR_W-1:0]);
                REG_HEIGHT: height_reg  <= cfg_data[LEN_W-1:0];
                REG_RADIUS: radius_reg  <= cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    // base center, scaled height and squared radius
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ah_prod[i] = axis_reg[i] * $signed({1'b0, height_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cen_reg[i] <= 34'(apex_reg[i]) + $signed(ah_prod[i][49:FRAC_BITS]);
        end
        hq_reg  <= {height_reg, {FRAC_BITS{1'b0}}};
        rsq_reg <= (2*LEN_W)'(height_reg - height_reg) + (2*LEN_W)'(radius_reg) *
                   (2*LEN_W)'(radius_reg);
    end

    // global stall: every stage advances together
    assign adv           = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray_reg <= ray_t'(s_axis_tdata[RAY_W-1:0]);
        end
    end

    assign geom_in.org = {ray_reg.origin_z, ray_reg.origin_y, ray_reg.origin_x};
    assign geom_in.dir = {ray_reg.direction_z, ray_reg.direction_y, ray_reg.direction_x};

    // ---------------- side surface ----------------

    rci_isqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    ({ray_reg.discriminant, {FRAC_BITS{1'b0}}}),
        .root (sq_root)
    );

    rci_delay #(.W(2*COORD_W), .N(ST_SQRT)) u_ab_dly (
        .clk (clk),
        .en  (adv),
        .d   ({ray_reg.coef_a, ray_reg.coef_b}),
        .q   (ab_d)
    );

    // root numerators and doubled a
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn0_reg <= -34'($signed(ab_d[COORD_W-1:0])) - 34'(sq_root);
            sn1_reg <= -34'($signed(ab_d[COORD_W-1:0])) + 34'(sq_root);
            sd_reg  <= $signed({ab_d[2*COORD_W-1:COORD_W], 1'b0});
            anz_reg <= (ab_d[2*COORD_W-1:COORD_W] != '0);
        end
    end

    rci_qdiv #(.NUM_W(34), .DEN_W(33)) u_sdiv0 (
        .clk (clk),
        .en  (adv),
        .num (sn0_reg),
        .den (sd_reg),
        .q   (st_div[0])
    );

    rci_qdiv #(.NUM_W(34), .DEN_W(33)) u_sdiv1 (
        .clk (clk),
        .en  (adv),
        .num (sn1_reg),
        .den (sd_reg),
        .q   (st_div[1])
    );

    rci_delay #(.W(1), .N(DIV_LAT)) u_anz_dly (
        .clk (clk),
        .en  (adv),
        .d   (anz_reg),
        .q   (anz_d)
    );

    rci_delay #(.W(GEOM_W), .N(ST_SDIV)) u_sg_dly (
        .clk (clk),
        .en  (adv),
        .d   (geom_in),
        .q   (side_g)
    );

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sdt_prod[k][i] = $signed(side_g.dir[i]) * st_div[k];
            end
        end
    end

    // hit point step, projection products and sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 2; k++)
            begin
                st_reg[0][k]   <= st_div[k];
                stok_reg[0][k] <= anz_d && !st_div[k][Q_W-1];
                for (int s = 1; s < 4; s++)
                begin
                    st_reg[s][k]   <= st_reg[s-1][k];
                    stok_reg[s][k] <= stok_reg[s-1][k];
                end
                for (int i = 0; i < 3; i++)
                begin
                    sdt_reg[k][i] <= sdt_prod[k][i][49:FRAC_BITS];
                    sh_reg[k][i]  <= 35'(soa_reg[i]) + 35'(sdt_reg[k][i]);
                    sp_reg[k][i]  <= sh_reg[k][i] * axis_reg[i];
                end
                sproj_reg[k] <= 55'(sp_reg[k][0]) + 55'(sp_reg[k][1]) + 55'(sp_reg[k][2]);
            end
            for (int i = 0; i < 3; i++)
            begin
                soa_reg[i] <= 33'($signed(side_g.org[i])) - 33'(apex_reg[i]);
            end
        end
    end

    // projection inside the finite height
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            sv_ok[k] = stok_reg[3][k] && !sproj_reg[k][54] &&
                       (sproj_reg[k] <= $signed({8'b0, hq_reg}));
        end
    end

    // nearest valid root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_hit_reg <= sv_ok[0] || sv_ok[1];
            if (sv_ok[0] && sv_ok[1])
            begin
                side_t_reg <= (st_reg[3][1] < st_reg[3][0]) ? st_reg[3][1] : st_reg[3][0];
            end
            else if (sv_ok[0])
            begin
                side_t_reg <= st_reg[3][0];
            end
            else if (sv_ok[1])
            begin
                side_t_reg <= st_reg[3][1];
            end
            else
            begin
                side_t_reg <= MISS_T;
            end
        end
    end

    // ---------------- base disk ----------------

    // plane numerator and denominator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bco_reg[i]  <= 35'(cen_reg[i]) - 35'($signed(geom_in.org[i]));
                bda_reg[i]  <= $signed(geom_in.dir[i]) * axis_reg[i];
                bnp_reg[i]  <= bco_reg[i] * axis_reg[i];
                bda2_reg[i] <= bda_reg[i];
            end
            bnum_reg <= 55'(bnp_reg[0]) + 55'(bnp_reg[1]) + 55'(bnp_reg[2]);
            bden_reg <= 38'(bda2_reg[0]) + 38'(bda2_reg[1]) + 38'(bda2_reg[2]);
        end
    end

    // near-parallel rays never hit the base
    assign bden_abs = bden_reg[37] ? 38'(-bden_reg) : 38'(bden_reg);
    assign den_ok   = (64'(bden_abs) > EPS);

    rci_qdiv #(.NUM_W(55), .DEN_W(38)) u_bdiv (
        .clk (clk),
        .en  (adv),
        .num (bnum_reg),
        .den (bden_reg),
        .q   (bt_div)
    );

    rci_delay #(.W(1), .N(DIV_LAT)) u_bok_dly (
        .clk (clk),
        .en  (adv),
        .d   (den_ok),
        .q   (bok_d)
    );

    rci_delay #(.W(GEOM_W), .N(ST_BDIV)) u_bg_dly (
        .clk (clk),
        .en  (adv),
        .d   (geom_in),
        .q   (base_g)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bdt_prod[i] = $signed(base_g.dir[i]) * bt_div;
            babs[i]     = bh_reg[i][35] ? 36'(-bh_reg[i]) : 36'(bh_reg[i]);
        end
    end

    // offset from the base center and its squared length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bt_reg[0]  <= bt_div;
            bok_reg[0] <= bok_d && !bt_div[Q_W-1] && (bt_div != '0);
            for (int s = 1; s < 4; s++)
            begin
                bt_reg[s] <= bt_reg[s-1];
            end
            for (int s = 1; s < 3; s++)
            begin
                bok_reg[s] <= bok_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                bdt_reg[i]  <= bdt_prod[i][49:FRAC_BITS];
                boc_reg[i]  <= 35'($signed(base_g.org[i])) - 35'(cen_reg[i]);
                bh_reg[i]   <= 36'(boc_reg[i]) + 36'(bdt_reg[i]);
                bout_reg[i] <= babs[i] > 36'(radius_reg);
                buh_reg[i]  <= babs[i][LEN_W-1:0];
                bsq_reg[i]  <= (2*LEN_W)'(buh_reg[i]) * (2*LEN_W)'(buh_reg[i]);
            end
            bin_reg <= bok_reg[2] && !bout_reg[0] && !bout_reg[1] && !bout_reg[2];
        end
    end

    // disk test
    assign bsum = 64'(bsq_reg[0]) + 64'(bsq_reg[1]) + 64'(bsq_reg[2]);
    assign bhit = bin_reg && (bsum <= 64'(rsq_reg));
    assign bres = {bhit, bhit ? bt_reg[3] : MISS_T};

    rci_delay #(.W(Q_W+1), .N(ST_OUT - ST_BRES)) u_bres_dly (
        .clk (clk),
        .en  (adv),
        .d   (bres),
        .q   (bres_d)
    );

    // output transaction
    assign res.side_t   = side_t_reg;
    assign res.side_hit = side_hit_reg;
    assign res.base_t   = $signed(bres_d[Q_W-1:0]);
    assign res.base_hit = bres_d[Q_W];

    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res};

endmodule

FILE: sv/ray_cone_intersection_chk.sv
// port-level checker for the ray cone intersection block, bound to the top level
`include "ray_cone_intersection_assert.svh"

module ray_cone_intersection_chk import rci_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_ADDR_W-1:0]  cfg_addr,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    // a waiting result holds its payload
    `RCI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output transaction changed while stalled")

    // output back-pressure reaches the input
    `RCI_ASSERT_NOW(a_stall_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

    // a missed test reports minus one
    `RCI_ASSERT_NOW(a_miss_code, m_axis_tvalid && (!m_axis_tdata[32] || !m_axis_tdata[65]), (m_axis_tdata[32] || (m_axis_tdata[31:0] == 32'hFFFF0000)) && (m_axis_tdata[65] || (m_axis_tdata[64:33] == 32'hFFFF0000)), "miss without minus one")

    // reset empties the pipeline
    `RCI_ASSERT_RST(a_rst_empty, !m_axis_tvalid, "result valid during reset")

endmodule

bind ray_cone_intersection ray_cone_intersection_chk u_chk (.*);

FILE: verif/ray_cone_intersection_checker.sv
// checker for ray_cone_intersection: watches all channels, predicts and compares results
module ray_cone_intersection_checker import rci_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending,
    output int                     rays_seen,
    output int                     side_hits,
    output int                     base_hits
);

    // shadow copy of the cone registers
    logic [31:0] cone_reg [8];
    result_t     hits_due [$];

    // floor of the square root
    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // num / den in fixed point, truncated toward zero, saturated to 32 bits
    function automatic longint fixed_div(longint num, longint den);
        bit          neg;
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] lim;
        logic [63:0] q;
        logic [63:0] rem;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        q   = un / ud;
        rem = un % ud;
        if (q > lim)
            q = lim;
        else
        begin
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                q   = q << 1;
                rem = rem << 1;
                if (rem >= ud)
                begin
                    rem = rem - ud;
                    q   = q + 1;
                end
                if (q > lim)
                begin
                    q = lim;
                    break;
                end
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // expected side and base intersection for one ray
    function automatic result_t cone_hit(ray_t r);
        result_t     res;
        longint      o [3];
        longint      d [3];
        longint      apex [3];
        longint      ax [3];
        longint      cen [3];
        longint      height;
        longint      radius;
        longint      a;
        longint      b;
        longint      s;
        longint      n;
        longint      t;
        longint      proj;
        longint      h;
        longint      den;
        longint      num;
        logic [63:0] uh;
        logic [63:0] sum;
        logic [63:0] aden;
        bit          in_disk;
        o[0] = r.origin_x;
        o[1] = r.origin_y;
        o[2] = r.origin_z;
        d[0] = r.direction_x;
        d[1] = r.direction_y;
        d[2] = r.direction_z;
        a = r.coef_a;
        b = r.coef_b;
        height = longint'(cone_reg[REG_HEIGHT][30:0]);
        radius = longint'(cone_reg[REG_RADIUS][30:0]);
        for (int i = 0; i < 3; i++)
        begin
            apex[i] = longint'($signed(cone_reg[i]));
            ax[i]   = longint'($signed(cone_reg[3 + i][17:0]));
            cen[i]  = apex[i] + ((ax[i] * height) >>> FRAC_BITS);
        end
        res.side_t   = MISS_T;
        res.side_hit = 1'b0;
        res.base_t   = MISS_T;
        res.base_hit = 1'b0;

        // side surface, nearest root inside the finite height
        if (a != 0)
        begin
            s = longint'(int_sqrt({33'd0, r.discriminant} << FRAC_BITS));
            for (int k = 0; k < 2; k++)
            begin
                n = (k == 0) ? (-b - s) : (-b + s);
                t = fixed_div(n, 2 * a);
                if (t >= 0)
                begin
                    proj = 0;
                    for (int i = 0; i < 3; i++)
                    begin
                        h = (o[i] - apex[i]) + ((d[i] * t) >>> FRAC_BITS);
                        proj += h * ax[i];
                    end
                    if (proj >= 0 && proj <= (height <<< FRAC_BITS))
                    begin
                        if (!res.side_hit || t < longint'(res.side_t))
                            res.side_t = t[31:0];
                        res.side_hit = 1'b1;
                    end
                end
            end
        end

        // base disk
        den = 0;
        num = 0;
        for (int i = 0; i < 3; i++)
        begin
            den += d[i] * ax[i];
            num += (cen[i] - o[i]) * ax[i];
        end
        aden = (den < 0) ? -den : den;
        if (aden > EPS)
        begin
            t = fixed_div(num, den);
            if (t > 0)
            begin
                sum     = 0;
                in_disk = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    h  = o[i] + ((d[i] * t) >>> FRAC_BITS) - cen[i];
                    uh = (h < 0) ? -h : h;
                    if (uh > radius)
                    begin
                        in_disk = 1'b0;
                        break;
                    end
                    sum += uh * uh;
                end
                if (in_disk && sum <= radius * radius)
                begin
                    res.base_t   = t[31:0];
                    res.base_hit = 1'b1;
                end
            end
        end
        return res;
    endfunction

    assign pending = hits_due.size();

    // track register writes, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            cone_reg[REG_APEX_X] <= 32'd0;
            cone_reg[REG_APEX_Y] <= 32'd0;
            cone_reg[REG_APEX_Z] <= 32'd0;
            cone_reg[REG_AXIS_X] <= 32'd0;
            cone_reg[REG_AXIS_Y] <= 32'd65536;
            cone_reg[REG_AXIS_Z] <= 32'd0;
            cone_reg[REG_HEIGHT] <= 32'd65536;
            cone_reg[REG_RADIUS] <= 32'd65536;
            hits_due.delete();
            mismatches = 0;
            rays_seen  = 0;
            side_hits  = 0;
            base_hits  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cone_reg[cfg_addr] <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = cone_hit(ray_t'(s_axis_tdata[RAY_W-1:0]));
                hits_due.push_back(want);
                rays_seen++;
                side_hits += want.side_hit;
                base_hits += want.base_hit;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[RES_W-1:0]);
                if (hits_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %h", got);
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (got.side_t !== want.side_t || got.side_hit !== want.side_hit ||
                        got.base_t !== want.base_t || got.base_hit !== want.base_hit)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("exp/act side_t %0d/%0d %0b/%0b base_t %0d/%0d %0b/%0b",
                                want.side_t, got.side_t, want.side_hit, got.side_hit,
                                want.base_t, got.base_t, want.base_hit, got.base_hit);
                    end
                end
            end
        end
    end

endmodule

FILE: verif/ray_cone_intersection_tb.sv
// top of the ray_cone_intersection testbench: clock, reset, stimulus and verdict
module ray_cone_intersection_tb;
    import rci_pkg::*;

    localparam int LATENCY_WAIT = 100;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    // coef_a, coef_b, discriminant, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // side_t, side_hit, base_t, base_hit, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int  mismatches;
    int  pending;
    int  rays_seen;
    int  side_hits;
    int  base_hits;
    int  quiet_cycles;
    bit  calm;
    bit  hold_req;
    int  settings_run;
    logic [31:0] apex_now [3];

    ray_cone_intersection dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    ray_cone_intersection_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .rays_seen     (rays_seen),
        .side_hits     (side_hits),
        .base_hits     (base_hits)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // result side: random bursts of back pressure, one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (calm || $urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("ray_cone_intersection regression: fail");
            $finish;
        end
    end

    // one register write; called at a clock edge, returns at the accepting edge
    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        if (idx <= REG_APEX_Z)
            apex_now[idx] = val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // load a whole cone setting
    task automatic load_cone(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] hgt, logic [31:0] rad);
        write_reg(REG_APEX_X, ax);
        write_reg(REG_APEX_Y, ay);
        write_reg(REG_APEX_Z, az);
        write_reg(REG_AXIS_X, nx & 32'h3ffff);
        write_reg(REG_AXIS_Y, ny & 32'h3ffff);
        write_reg(REG_AXIS_Z, nz & 32'h3ffff);
        write_reg(REG_HEIGHT, hgt & 32'h7fffffff);
        write_reg(REG_RADIUS, rad & 32'h7fffffff);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // offer one ray, at times after a random gap; returns at the accepting edge
    task automatic send_ray(ray_t r);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - RAY_W){1'b0}}, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [17:0] rand_dir();
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic ray_t build_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                       logic [17:0] dx, logic [17:0] dy, logic [17:0] dz,
                                       logic [31:0] ca, logic [31:0] cb, logic [30:0] dsc);
        ray_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.direction_x = dx;
        r.direction_y = dy;
        r.direction_z = dz;
        r.coef_a = ca;
        r.coef_b = cb;
        r.discriminant = dsc;
        return r;
    endfunction

    // random ray: mostly small rays near the apex, some full range noise
    function automatic ray_t random_ray();
        ray_t r;
        if ($urandom_range(0, 3) != 0)
        begin
            r = build_ray(apex_now[0] + 32'($signed($urandom_range(0, 524288)) - 262144),
                          apex_now[1] + 32'($signed($urandom_range(0, 524288)) - 262144),
                          apex_now[2] + 32'($signed($urandom_range(0, 524288)) - 262144),
                          rand_dir(), rand_dir(), rand_dir(),
                          32'($signed($urandom_range(0, 524288)) - 262144),
                          32'($signed($urandom_range(0, 1048576)) - 524288),
                          31'($urandom_range(0, 1048576)));
        end
        else
        begin
            r = build_ray($urandom, $urandom, $urandom,
                          rand_dir(), rand_dir(), rand_dir(),
                          $urandom, $urandom, 31'($urandom));
        end
        return r;
    endfunction

    // random rays under the current setting, then drain
    task automatic run_rays(int count, bit with_hold);
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 2)
                hold_req = 1'b1;
            send_ray(random_ray());
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0 || hold_req)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_addr      <= REG_APEX_X;
        cfg_data      <= '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        settings_run  = 0;
        apex_now[0]   = 32'd0;
        apex_now[1]   = 32'd0;
        apex_now[2]   = 32'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rays under the reset cone (apex 0, axis +y, height 1, radius 1)
        // straight down the axis: base at center, side roots outside the height
        send_ray(build_ray(0, 32'sd196608, 0, 0, -18'sd65536, 0,
                           32'sd65536, -32'sd131072, 0));
        // root inside the height, from below
        send_ray(build_ray(32'sd32768, -32'sd65536, 0, 0, 18'sd65536, 0,
                           32'sd65536, -32'sd196608, 31'd65536));
        // zero a: no side hit
        send_ray(build_ray(0, 32'sd196608, 0, 0, -18'sd65536, 0, 0, 32'sd65536, 31'd65536));
        // ray perpendicular to the axis: no base hit
        send_ray(build_ray(-32'sd131072, 32'sd32768, 0, 18'sd65536, 0, 0,
                           32'sd65536, -32'sd131072, 31'd65536));
        // base plane behind the ray
        send_ray(build_ray(0, 32'sd196608, 0, 0, 18'sd65536, 0,
                           -32'sd65536, 32'sd131072, 31'd131072));
        // base plane hit outside the radius
        send_ray(build_ray(32'sd196608, 32'sd196608, 0, 0, -18'sd65536, 0,
                           32'sd65536, 0, 31'd65536));
        // both roots negative
        send_ray(build_ray(0, 0, 0, 18'sd65536, 18'sd65536, 18'sd65536,
                           32'sd65536, 32'sd655360, 31'd65536));
        // field extremes
        send_ray(build_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           18'sd65536, 18'sd65536, 18'sd65536,
                           32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
        send_ray(build_ray(32'h80000000, 32'h80000000, 32'h80000000,
                           -18'sd65536, -18'sd65536, -18'sd65536,
                           32'h80000000, 32'h80000000, 31'h7fffffff));
        send_ray(build_ray(0, 0, 0, 0, 0, 0, 32'sd1, 32'h80000000, 0));
        send_ray(build_ray(0, -32'sd65536, 0, 0, 18'sd1, 0, 32'sd1, -32'sd1, 31'h7fffffff));
        send_ray(build_ray(32'h80000000, 32'h7fffffff, 0, 18'sd65536, -18'sd65536, 0,
                           -32'sd1, 32'h7fffffff, 31'd0));
        // quotient saturation on the base divide
        send_ray(build_ray(0, 32'h80000000, 0, 0, 18'sd1, 0, 32'sd65536, 0, 0));
        send_ray(build_ray(0, 32'h7fffffff, 0, 0, -18'sd1, 0, 32'sd65536, 0, 0));
        run_rays(110, 1'b0);

        // small cone pointing down -z; long output hold during this setting
        load_cone(32'sd65536, -32'sd131072, 32'sd32768, 0, 0, -32'sd65536,
                  32'sd196608, 32'sd131072);
        run_rays(110, 1'b1);

        // extremes: apex at the corners, non-unit axis, longest cone, zero radius
        load_cone(32'h7fffffff, 32'h80000000, 0, 32'sd65536, -32'sd65536, 32'sd65536,
                  32'h7fffffff, 0);
        run_rays(70, 1'b0);

        // tilted axis, zero height, widest radius
        load_cone(0, 0, 0, 32'sd46341, 32'sd46341, 0, 0, 32'h7fffffff);
        run_rays(70, 1'b0);

        // last stretch with no idling on either side
        calm = 1'b1;
        load_cone(0, 32'sd65536, 0, 0, 32'sd65536, 0, 32'sd131072, 32'sd65536);
        run_rays(100, 1'b0);

        $display("%0d rays under reset defaults and %0d cone settings, one long output hold",
                 rays_seen, settings_run);
        $display("%0d side hits and %0d base hits predicted, %0d mismatches",
                 side_hits, base_hits, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("ray_cone_intersection regression: pass");
        else
            $display("ray_cone_intersection regression: fail");
        $finish;
    end

endmodule

FILE: ray_cone_intersection.f
+incdir+sv
sv/rci_pkg.sv
sv/rci_delay.sv
sv/rci_isqrt.sv
sv/rci_qdiv.sv
sv/ray_cone_intersection.sv
sv/ray_cone_intersection_chk.sv
verif/ray_cone_intersection_checker.sv
verif/ray_cone_intersection_tb.sv
